// ===== design/dlbm_pkg.sv =====
// Shared constants, codes and interface types for the dice letter matcher.
// Depends on nothing; every other design file imports it.
`default_nettype none

package dlbm_pkg;

   // Store sizes
   localparam int MAX_DICE    = 16;
   localparam int MAX_FACES   = 8;
   localparam int MAX_LETTERS = 16;
   localparam int SYM_W       = 8;

   // Index and count widths
   localparam int DIE_W       = $clog2(MAX_DICE);
   localparam int FACE_W      = $clog2(MAX_FACES);
   localparam int LET_W       = $clog2(MAX_LETTERS);
   localparam int DCNT_W      = $clog2(MAX_DICE + 1);
   localparam int FCNT_W      = $clog2(MAX_FACES + 1);
   localparam int LCNT_W      = $clog2(MAX_LETTERS + 1);
   localparam int SCAN_W      = (DCNT_W > LCNT_W) ? DCNT_W : LCNT_W;
   localparam int NODE_IDX_W  = (DIE_W > LET_W) ? DIE_W : LET_W;
   localparam int FACE_ADDR_W = DIE_W + FACE_W;
   localparam int FACE_DEPTH  = MAX_DICE * MAX_FACES;

   // Search queue holds dice and letter nodes only
   localparam int QUEUE_DEPTH = MAX_DICE + MAX_LETTERS;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register widths and indexes
   localparam int CFG_DICE_W  = 5;
   localparam int CFG_FACES_W = 4;
   localparam int CSR_DATA_W  = 5;
   localparam logic CSR_DICE_IN_USE   = 1'b0;
   localparam logic CSR_FACES_PER_DIE = 1'b1;
   localparam logic [CFG_FACES_W-1:0] FACES_RESET = 4'd6;

   // Request opcodes
   localparam logic OP_LOAD_FACE = 1'b0;
   localparam logic OP_LETTER    = 1'b1;

   // Start command to the matcher
   typedef struct packed {
      logic              start;
      logic [DCNT_W-1:0] nd;
      logic [FCNT_W-1:0] nf;
      logic [LCNT_W-1:0] nl;
   } match_cmd_type;

   // Completion status from the matcher
   typedef struct packed {
      logic done;
      logic ok;
   } match_stat_type;

endpackage

`default_nettype wire

// ===== design/dlbm_face_ram.sv =====
// Die face symbol table: one write port, one registered read port.
// Depends on dlbm_pkg for sizes.
`default_nettype none

module dlbm_face_ram
   import dlbm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [FACE_ADDR_W-1:0] wr_addr,
   input  wire logic [SYM_W-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [FACE_ADDR_W-1:0] rd_addr,
   output logic      [SYM_W-1:0]       rd_data
);

   logic [SYM_W-1:0] mem_ff [FACE_DEPTH];

   // Write a face symbol
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/dlbm_matcher.sv =====
// Matching sequencer: builds the die/letter compatibility matrix from the
// face table, then runs breadth-first augmenting searches. Uses dlbm_pkg.
`default_nettype none

module dlbm_matcher
   import dlbm_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire match_cmd_type                        cmd,
   input  wire logic [MAX_LETTERS-1:0][SYM_W-1:0]    letters,
   output logic                                      face_rd,
   output logic      [FACE_ADDR_W-1:0]               face_addr,
   input  wire logic [SYM_W-1:0]                     face_data,
   output match_stat_type                            stat,
   output logic      [MAX_LETTERS-1:0][DIE_W-1:0]    letter_die
);

   localparam logic [3:0] M_IDLE = 4'd0;
   localparam logic [3:0] M_FILL = 4'd1;
   localparam logic [3:0] M_WAIT = 4'd2;
   localparam logic [3:0] M_INIT = 4'd3;
   localparam logic [3:0] M_SRC  = 4'd4;
   localparam logic [3:0] M_POP  = 4'd5;
   localparam logic [3:0] M_DIE  = 4'd6;
   localparam logic [3:0] M_LET  = 4'd7;
   localparam logic [3:0] M_AUG  = 4'd8;
   localparam logic [3:0] M_FIN  = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [DCNT_W-1:0]           nd_ff, nd_in;
   logic [FCNT_W-1:0]           nf_ff, nf_in;
   logic [LCNT_W-1:0]           nl_ff, nl_in;
   logic [DCNT_W-1:0]           fd_ff, fd_in;
   logic [FCNT_W-1:0]           fi_ff, fi_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [DIE_W-1:0]            rd_die_ff, rd_die_in;
   logic [MAX_DICE-1:0][MAX_LETTERS-1:0] cs_ff, cs_in;
   logic [MAX_LETTERS-1:0]      ltd_vld_ff, ltd_vld_in;
   logic [MAX_LETTERS-1:0][DIE_W-1:0] ltd_ff, ltd_in;
   logic [MAX_DICE-1:0]         dm_ff, dm_in;
   logic [MAX_DICE-1:0]         dvis_ff, dvis_in;
   logic [MAX_LETTERS-1:0]      lvis_ff, lvis_in;
   logic [MAX_DICE-1:0]         dpar_src_ff, dpar_src_in;
   logic [MAX_DICE-1:0][LET_W-1:0] dpar_ff, dpar_in;
   logic [MAX_LETTERS-1:0][DIE_W-1:0] lpar_ff, lpar_in;
   logic [QUEUE_DEPTH-1:0][NODE_IDX_W:0] q_ff, q_in;
   logic [QPTR_W-1:0]           head_ff, head_in;
   logic [QPTR_W-1:0]           tail_ff, tail_in;
   logic [NODE_IDX_W:0]         cur_ff, cur_in;
   logic [SCAN_W-1:0]           scan_ff, scan_in;
   logic [LET_W-1:0]            aug_ff, aug_in;
   logic                        done_ff, done_in;
   logic                        ok_ff, ok_in;

   logic [DIE_W-1:0]            d_sel;
   logic [LET_W-1:0]            l_sel;
   logic                        all_ok;

   assign face_addr  = {fd_ff[DIE_W-1:0], fi_ff[FACE_W-1:0]};
   assign stat.done  = done_ff;
   assign stat.ok    = ok_ff;
   assign letter_die = ltd_ff;

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      nd_in       = nd_ff;
      nf_in       = nf_ff;
      nl_in       = nl_ff;
      fd_in       = fd_ff;
      fi_in       = fi_ff;
      rd_vld_in   = 1'b0;
      rd_die_in   = rd_die_ff;
      cs_in       = cs_ff;
      ltd_vld_in  = ltd_vld_ff;
      ltd_in      = ltd_ff;
      dm_in       = dm_ff;
      dvis_in     = dvis_ff;
      lvis_in     = lvis_ff;
      dpar_src_in = dpar_src_ff;
      dpar_in     = dpar_ff;
      lpar_in     = lpar_ff;
      q_in        = q_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_in      = cur_ff;
      scan_in     = scan_ff;
      aug_in      = aug_ff;
      done_in     = 1'b0;
      ok_in       = ok_ff;
      face_rd     = 1'b0;
      d_sel       = '0;
      l_sel       = '0;
      all_ok      = 1'b1;

      // Mark letters that match the returned face
      if (rd_vld_ff) begin
         for (int l = 0; l < MAX_LETTERS; l++) begin
            if ((LCNT_W'(l) < nl_ff) && (face_data == letters[l])) begin
               cs_in[rd_die_ff][l] = 1'b1;
            end
         end
      end

      case (state_ff)
         M_IDLE: begin
            if (cmd.start) begin
               nd_in      = cmd.nd;
               nf_in      = cmd.nf;
               nl_in      = cmd.nl;
               fd_in      = '0;
               fi_in      = '0;
               cs_in      = '0;
               ltd_vld_in = '0;
               dm_in      = '0;
               state_in   = M_FILL;
            end
         end
         // Scan every used face of every used die
         M_FILL: begin
            if ((fd_ff >= nd_ff) || (nf_ff == '0)) begin
               state_in = M_WAIT;
            end else begin
               face_rd   = 1'b1;
               rd_vld_in = 1'b1;
               rd_die_in = fd_ff[DIE_W-1:0];
               if (fi_ff + FCNT_W'(1) == nf_ff) begin
                  fi_in = '0;
                  fd_in = fd_ff + DCNT_W'(1);
               end else begin
                  fi_in = fi_ff + FCNT_W'(1);
               end
            end
         end
         M_WAIT: begin
            state_in = M_INIT;
         end
         // Start a new search
         M_INIT: begin
            dvis_in  = '0;
            lvis_in  = '0;
            head_in  = '0;
            tail_in  = '0;
            scan_in  = '0;
            state_in = M_SRC;
         end
         // Source visits free dice by index
         M_SRC: begin
            if (scan_ff < SCAN_W'(nd_ff)) begin
               d_sel = scan_ff[DIE_W-1:0];
               if (!dm_ff[d_sel]) begin
                  dvis_in[d_sel]           = 1'b1;
                  dpar_src_in[d_sel]       = 1'b1;
                  q_in[tail_ff[QIDX_W-1:0]] = {1'b0, NODE_IDX_W'(d_sel)};
                  tail_in                  = tail_ff + QPTR_W'(1);
               end
               scan_in = scan_ff + SCAN_W'(1);
            end else begin
               state_in = M_POP;
            end
         end
         // Take the next node off the queue
         M_POP: begin
            if (head_ff == tail_ff) begin
               state_in = M_FIN;
            end else begin
               cur_in   = q_ff[head_ff[QIDX_W-1:0]];
               head_in  = head_ff + QPTR_W'(1);
               scan_in  = '0;
               state_in = q_ff[head_ff[QIDX_W-1:0]][NODE_IDX_W] ? M_LET : M_DIE;
            end
         end
         // Die visits compatible letters it does not hold
         M_DIE: begin
            d_sel = cur_ff[DIE_W-1:0];
            if (scan_ff < SCAN_W'(nl_ff)) begin
               l_sel = scan_ff[LET_W-1:0];
               if (cs_ff[d_sel][l_sel] && !lvis_ff[l_sel] &&
                   !(ltd_vld_ff[l_sel] && (ltd_ff[l_sel] == d_sel))) begin
                  lvis_in[l_sel]           = 1'b1;
                  lpar_in[l_sel]           = d_sel;
                  q_in[tail_ff[QIDX_W-1:0]] = {1'b1, NODE_IDX_W'(l_sel)};
                  tail_in                  = tail_ff + QPTR_W'(1);
               end
               scan_in = scan_ff + SCAN_W'(1);
            end else begin
               state_in = M_POP;
            end
         end
         // Letter reaches the sink if free, else steps back to its die
         M_LET: begin
            l_sel = cur_ff[LET_W-1:0];
            if (!ltd_vld_ff[l_sel]) begin
               aug_in   = l_sel;
               state_in = M_AUG;
            end else begin
               d_sel = ltd_ff[l_sel];
               if (!dvis_ff[d_sel]) begin
                  dvis_in[d_sel]           = 1'b1;
                  dpar_src_in[d_sel]       = 1'b0;
                  dpar_in[d_sel]           = l_sel;
                  q_in[tail_ff[QIDX_W-1:0]] = {1'b0, NODE_IDX_W'(d_sel)};
                  tail_in                  = tail_ff + QPTR_W'(1);
               end
               state_in = M_POP;
            end
         end
         // Flip one letter/die pair of the path per cycle
         M_AUG: begin
            l_sel             = aug_ff;
            d_sel             = lpar_ff[l_sel];
            ltd_vld_in[l_sel] = 1'b1;
            ltd_in[l_sel]     = d_sel;
            dm_in[d_sel]      = 1'b1;
            if (dpar_src_ff[d_sel]) begin
               state_in = M_INIT;
            end else begin
               aug_in = dpar_ff[d_sel];
            end
         end
         // Report whether every letter holds a die
         M_FIN: begin
            for (int l = 0; l < MAX_LETTERS; l++) begin
               if ((LCNT_W'(l) < nl_ff) && !ltd_vld_ff[l]) begin
                  all_ok = 1'b0;
               end
            end
            ok_in    = all_ok;
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= M_IDLE;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      nd_ff       <= nd_in;
      nf_ff       <= nf_in;
      nl_ff       <= nl_in;
      fd_ff       <= fd_in;
      fi_ff       <= fi_in;
      rd_die_ff   <= rd_die_in;
      cs_ff       <= cs_in;
      ltd_vld_ff  <= ltd_vld_in;
      ltd_ff      <= ltd_in;
      dm_ff       <= dm_in;
      dvis_ff     <= dvis_in;
      lvis_ff     <= lvis_in;
      dpar_src_ff <= dpar_src_in;
      dpar_ff     <= dpar_in;
      lpar_ff     <= lpar_in;
      q_ff        <= q_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      aug_ff      <= aug_in;
      ok_ff       <= ok_in;
   end

endmodule

`default_nettype wire

// ===== design/dice_letter_bipartite_matcher_core.sv =====
// Top level of the dice letter matcher: stream ports, letter store, result
// output. Depends on dlbm_pkg, dlbm_face_ram and dlbm_matcher.
//
// A face load beat or a non-final letter beat is simply stored. The final
// letter of a word starts a match. First the face table is scanned one face a
// cycle through its single read port. Then up to one breadth-first search
// runs per letter, plus a final one that finds no path. A search consists of:
//   - a start step and a source scan over the used dice;
//   - for every dequeued die, a pop step, a scan over the letters and an exit;
//   - a pop step and a letter step for every dequeued letter;
//   - an augment step for every path pair, or a pop and a finish step
//     when no path is left.
// req_tready stays low while a word is matched and while its results are
// delivered, one result beat per cycle while rsp_tready is high. A too-long
// word answers at once. dice_in_use above 16 and faces_per_die above 8 are
// clamped.
`default_nettype none

module dice_letter_bipartite_matcher_core
   import dlbm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // die_index[3:0], face_index[6:4], symbol[14:7]
   input  wire logic                  req_tuser,  // opcode
   input  wire logic                  req_tlast,  // last_letter
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [15:0]           rsp_tdata,  // can_spell[0], too_long[1],
                                                  // letter_position[5:2], die_number[9:6]
   output logic                       rsp_tlast,  // last
   // Configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_MATCH = 2'd1;
   localparam logic [1:0] T_EMIT  = 2'd2;

   logic [1:0]                     tstate_ff, tstate_in;
   logic [MAX_LETTERS-1:0][SYM_W-1:0] letters_ff, letters_in;
   logic [LCNT_W-1:0]              lcnt_ff, lcnt_in;
   logic                           ovf_ff, ovf_in;
   logic [LCNT_W-1:0]              nl_ff, nl_in;
   logic [CFG_DICE_W-1:0]          dice_ff, dice_in;
   logic [CFG_FACES_W-1:0]         faces_ff, faces_in;
   logic                           rvld_ff, rvld_in;
   logic                           can_ff, can_in;
   logic                           long_ff, long_in;
   logic [LET_W-1:0]               pos_ff, pos_in;
   logic [DIE_W-1:0]               die_ff, die_in;
   logic                           last_ff, last_in;

   logic                           accept;
   logic [DIE_W-1:0]               f_die;
   logic [FACE_W-1:0]              f_face;
   logic [SYM_W-1:0]               f_sym;
   logic [LCNT_W-1:0]              nxt;
   match_cmd_type                  cmd;
   match_stat_type                 stat;
   logic                           face_rd;
   logic [FACE_ADDR_W-1:0]         face_addr;
   logic [SYM_W-1:0]               face_data;
   logic [MAX_LETTERS-1:0][DIE_W-1:0] letter_die;

   assign req_tready = (tstate_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign f_die      = req_tdata[3:0];
   assign f_face     = req_tdata[6:4];
   assign f_sym      = req_tdata[14:7];
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = {6'b0, die_ff, pos_ff, long_ff, can_ff};
   assign rsp_tlast  = last_ff;

   dlbm_face_ram u_face_ram (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == OP_LOAD_FACE)),
      .wr_addr ({f_die, f_face}),
      .wr_data (f_sym),
      .rd_en   (face_rd),
      .rd_addr (face_addr),
      .rd_data (face_data)
   );

   dlbm_matcher u_matcher (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .letters    (letters_ff),
      .face_rd    (face_rd),
      .face_addr  (face_addr),
      .face_data  (face_data),
      .stat       (stat),
      .letter_die (letter_die)
   );

   // Word intake, result sequencing and configuration
   always_comb begin
      tstate_in  = tstate_ff;
      letters_in = letters_ff;
      lcnt_in    = lcnt_ff;
      ovf_in     = ovf_ff;
      nl_in      = nl_ff;
      dice_in    = dice_ff;
      faces_in   = faces_ff;
      rvld_in    = rvld_ff;
      can_in     = can_ff;
      long_in    = long_ff;
      pos_in     = pos_ff;
      die_in     = die_ff;
      last_in    = last_ff;
      nxt        = {1'b0, pos_ff} + LCNT_W'(1);
      cmd.start  = 1'b0;
      cmd.nd     = (dice_ff > CFG_DICE_W'(MAX_DICE)) ? DCNT_W'(MAX_DICE) : DCNT_W'(dice_ff);
      cmd.nf     = (faces_ff > CFG_FACES_W'(MAX_FACES)) ? FCNT_W'(MAX_FACES)
                                                       : FCNT_W'(faces_ff);
      cmd.nl     = lcnt_ff + LCNT_W'(1);

      // Apply register writes
      if (csr_valid) begin
         if (csr_index == CSR_DICE_IN_USE) begin
            dice_in = csr_wdata;
         end else begin
            faces_in = csr_wdata[CFG_FACES_W-1:0];
         end
      end

      case (tstate_ff)
         T_IDLE: begin
            if (accept && (req_tuser == OP_LETTER)) begin
               if (lcnt_ff < LCNT_W'(MAX_LETTERS)) begin
                  letters_in[lcnt_ff[LET_W-1:0]] = f_sym;
                  lcnt_in                        = lcnt_ff + LCNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  lcnt_in = '0;
                  ovf_in  = 1'b0;
                  if (ovf_ff || (lcnt_ff >= LCNT_W'(MAX_LETTERS))) begin
                     // Reject the word with one beat
                     rvld_in   = 1'b1;
                     can_in    = 1'b0;
                     long_in   = 1'b1;
                     pos_in    = '0;
                     die_in    = '0;
                     last_in   = 1'b1;
                     tstate_in = T_EMIT;
                  end else begin
                     cmd.start = 1'b1;
                     nl_in     = lcnt_ff + LCNT_W'(1);
                     tstate_in = T_MATCH;
                  end
               end
            end
         end
         T_MATCH: begin
            if (stat.done) begin
               rvld_in   = 1'b1;
               long_in   = 1'b0;
               pos_in    = '0;
               tstate_in = T_EMIT;
               if (stat.ok) begin
                  can_in  = 1'b1;
                  die_in  = letter_die[0];
                  last_in = (nl_ff == LCNT_W'(1));
               end else begin
                  can_in  = 1'b0;
                  die_in  = '0;
                  last_in = 1'b1;
               end
            end
         end
         // Advance through the letters as beats are taken
         T_EMIT: begin
            if (rvld_ff && rsp_tready) begin
               if (last_ff) begin
                  rvld_in   = 1'b0;
                  tstate_in = T_IDLE;
               end else begin
                  pos_in  = nxt[LET_W-1:0];
                  die_in  = letter_die[nxt[LET_W-1:0]];
                  last_in = (nxt + LCNT_W'(1) == nl_ff);
               end
            end
         end
         default: begin
            tstate_in = T_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tstate_ff <= T_IDLE;
         lcnt_ff   <= '0;
         ovf_ff    <= 1'b0;
         dice_ff   <= '0;
         faces_ff  <= FACES_RESET;
         rvld_ff   <= 1'b0;
      end else begin
         tstate_ff <= tstate_in;
         lcnt_ff   <= lcnt_in;
         ovf_ff    <= ovf_in;
         dice_ff   <= dice_in;
         faces_ff  <= faces_in;
         rvld_ff   <= rvld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      letters_ff <= letters_in;
      nl_ff      <= nl_in;
      can_ff     <= can_in;
      long_ff    <= long_in;
      pos_ff     <= pos_in;
      die_ff     <= die_in;
      last_ff    <= last_in;
   end

endmodule

`default_nettype wire
